FILE: design/ssp_pkg.sv
// Shared types, widths and constants of the stepper step pulse generator.
package ssp_pkg;

   // Field and state widths
   localparam int ANGLE_W   = 16;
   localparam int STEPS_W   = 22;
   localparam int COUNT_W   = 26;
   localparam int MODE_W    = 3;
   localparam int SPR_W     = 11;
   localparam int RPM_W     = 12;
   localparam int HIGH_W    = 8;
   localparam int PPR_W     = 16;
   localparam int MAG_W     = ANGLE_W + 1;
   localparam int PROD_W    = MAG_W + SPR_W;

   // Divider geometry: two quotient bits are resolved per cycle
   localparam int DIV_W       = 32;
   localparam int DIVISOR_W   = 16;
   localparam int DIV_CYCLES  = DIV_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   // Arithmetic constants
   localparam logic [DIV_W-1:0]     US_PER_MIN  = 32'd60000000;
   localparam logic [DIVISOR_W-1:0] DEG_PER_REV = 16'd360;
   localparam logic [STEPS_W-1:0]   STEPS_MAX   = 22'h3FFFFF;
   localparam logic [MODE_W-1:0]    MODE_LAST   = 3'd5;

   // Input function codes
   localparam logic FUNC_ANGLE = 1'b0;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;
   localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SPR  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RPM  = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_HIGH = 2'd3;

   // Register reset values
   localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;
   localparam logic [SPR_W-1:0]  SPR_RESET  = 11'd200;
   localparam logic [RPM_W-1:0]  RPM_RESET  = 12'd60;
   localparam logic [HIGH_W-1:0] HIGH_RESET = 8'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SPR_W-1:0]  spr;
      logic [RPM_W-1:0]  rpm;
      logic [HIGH_W-1:0] high;
   } cfg_type;

   // Phase of the step line
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   // Which quotient the shared divider produces
   typedef enum logic [1:0] {
      DIV_STEPS     = 2'd0,
      DIV_PER_REV   = 2'd1,
      DIV_PER_PULSE = 2'd2
   } div_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        take_req;
      logic        div_start;
      div_sel_type div_sel;
      logic        commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_cmd;
      logic pulse_start;
      logic div_done;
   } ctrl_stat_type;

   // Modes above the last table entry fall back to full step
   function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] mode);
      return (mode > MODE_LAST) ? '0 : mode;
   endfunction

endpackage

FILE: design/ssp_req_if.sv
// Input channel: angle commands and microsecond ticks.
interface ssp_req_if
   import ssp_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [ANGLE_W-1:0] angle_deg;

   modport source (output valid, output func, output angle_deg, input ready);
   modport sink   (input valid, input func, input angle_deg, output ready);
endinterface

FILE: design/ssp_rsp_if.sv
// Result channel: step line, directions, mode pins and pending step count.
interface ssp_rsp_if
   import ssp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               step_level;
   logic               dir_motor1;
   logic               dir_motor2;
   logic [MODE_W-1:0]  mode_pins;
   logic [STEPS_W-1:0] steps_left;
   logic               busy_res;

   modport source (output valid, output step_level, output dir_motor1, output dir_motor2,
                   output mode_pins, output steps_left, output busy_res, input ready);
   modport sink   (input valid, input step_level, input dir_motor1, input dir_motor2,
                   input mode_pins, input steps_left, input busy_res, output ready);
endinterface

FILE: design/ssp_csr.sv
// Configuration registers behind the APB-style port.
module ssp_csr
   import ssp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MODE: cfg_in.mode = pwdata[MODE_W-1:0];
            REG_SPR:  cfg_in.spr  = pwdata[SPR_W-1:0];
            REG_RPM:  cfg_in.rpm  = pwdata[RPM_W-1:0];
            REG_HIGH: cfg_in.high = pwdata[HIGH_W-1:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_RESET;
         cfg_ff.spr  <= SPR_RESET;
         cfg_ff.rpm  <= RPM_RESET;
         cfg_ff.high <= HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read decode
   always_comb begin
      unique case (reg_idx)
         REG_MODE: prdata = CSR_DATA_W'(cfg_ff.mode);
         REG_SPR:  prdata = CSR_DATA_W'(cfg_ff.spr);
         REG_RPM:  prdata = CSR_DATA_W'(cfg_ff.rpm);
         REG_HIGH: prdata = CSR_DATA_W'(cfg_ff.high);
         default:  prdata = '0;
      endcase
   end

endmodule

FILE: design/ssp_divider.sv
// Restoring unsigned divider resolving two quotient bits per cycle.
module ssp_divider
   import ssp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_W-1:0]     quotient
);

   localparam int RQ_W = DIVISOR_W + DIV_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RQ_W-1:0]      rq_ff, rq_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;

   // One restoring step on {remainder, dividend/quotient}
   function automatic logic [RQ_W-1:0] div_step(input logic [RQ_W-1:0] rq,
                                                input logic [DIVISOR_W-1:0] d);
      logic [DIVISOR_W:0] trial;
      logic [DIVISOR_W:0] diff;
      trial = {rq[RQ_W-1:DIV_W], rq[DIV_W-1]};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         return {diff[DIVISOR_W-1:0], rq[DIV_W-2:0], 1'b1};
      end else begin
         return {trial[DIVISOR_W-1:0], rq[DIV_W-2:0], 1'b0};
      end
   endfunction

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rq_in      = rq_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rq_in      = {{DIVISOR_W{1'b0}}, dividend};
         divisor_in = divisor;
      end else if (busy_ff) begin
         rq_in  = div_step(div_step(rq_ff, divisor_ff), divisor_ff);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rq_ff      <= rq_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = rq_ff[DIV_W-1:0];

endmodule

FILE: design/ssp_datapath.sv
// Datapath: step count, pulse timing state, divider operands and result register.
module ssp_datapath
   import ssp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  ctrl_cmd_type              cmd,
   output ctrl_stat_type             stat,
   input  logic                      req_func,
   input  logic signed [ANGLE_W-1:0] req_angle_deg,
   output logic                      rsp_step_level,
   output logic                      rsp_dir_motor1,
   output logic                      rsp_dir_motor2,
   output logic [MODE_W-1:0]         rsp_mode_pins,
   output logic [STEPS_W-1:0]        rsp_steps_left,
   output logic                      rsp_busy_res
);

   // Latched item
   logic               func_ff;
   logic [ANGLE_W-1:0] angle_ff;

   // Pulse generator state
   logic [STEPS_W-1:0] steps_ff, steps_in;
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] low_ff, low_in;
   logic               dir_cw_ff, dir_cw_in;

   // Result register
   logic               rsp_step_ff;
   logic               rsp_dir_ff;
   logic [MODE_W-1:0]  rsp_mode_ff;
   logic [STEPS_W-1:0] rsp_steps_ff;
   logic               rsp_busy_ff;

   // Derived values
   logic [MODE_W-1:0]    mode_eff;
   logic [PPR_W-1:0]     ppr;
   logic [COUNT_W-1:0]   high_eff;
   logic [MAG_W-1:0]     mag;
   logic [PROD_W-1:0]    mag_x_spr;
   logic [DIV_W-1:0]     prod;
   logic [DIV_W-1:0]     per_rev;
   logic [COUNT_W-1:0]   per_pulse;
   logic [COUNT_W-1:0]   low_calc;
   logic [STEPS_W-1:0]   steps_calc;
   logic [COUNT_W-1:0]   count_dec;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     div_q;

   // Pulses per revolution is the full step count scaled by the microstep power of two
   assign mode_eff  = eff_mode(cfg.mode);
   assign ppr       = PPR_W'(cfg.spr) << mode_eff;
   assign high_eff  = (cfg.high == '0) ? COUNT_W'(1) : COUNT_W'(cfg.high);

   // Magnitude of the commanded angle and the pulse product
   assign mag       = angle_ff[ANGLE_W-1] ? (MAG_W'(1) << ANGLE_W) - MAG_W'(angle_ff)
                                          : MAG_W'(angle_ff);
   assign mag_x_spr = PROD_W'(mag) * PROD_W'(cfg.spr);
   assign prod      = DIV_W'(mag_x_spr) << mode_eff;

   // Divider operand selection
   assign per_rev = (cfg.rpm == '0) ? US_PER_MIN : div_q;
   always_comb begin
      case (cmd.div_sel)
         DIV_STEPS: begin
            div_dividend = prod;
            div_divisor  = DEG_PER_REV;
         end
         DIV_PER_REV: begin
            div_dividend = US_PER_MIN;
            div_divisor  = DIVISOR_W'(cfg.rpm);
         end
         DIV_PER_PULSE: begin
            div_dividend = per_rev;
            div_divisor  = ppr;
         end
         default: begin
            div_dividend = prod;
            div_divisor  = DEG_PER_REV;
         end
      endcase
   end

   ssp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Quotient interpretation once the last division of an item is done
   assign steps_calc = (div_q > DIV_W'(STEPS_MAX)) ? STEPS_MAX : div_q[STEPS_W-1:0];
   assign per_pulse  = (ppr == '0) ? '0 : div_q[COUNT_W-1:0];
   assign low_calc   = (per_pulse < high_eff) ? high_eff : per_pulse - high_eff;
   assign count_dec  = count_ff - 1'b1;

   assign stat.is_cmd      = (func_ff == FUNC_ANGLE);
   assign stat.pulse_start = (phase_ff == PH_IDLE) && (steps_ff != '0);
   assign stat.div_done    = div_done;

   // Item update, applied when the result is committed
   always_comb begin
      steps_in  = steps_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      low_in    = low_ff;
      dir_cw_in = dir_cw_ff;
      if (cmd.commit) begin
         if (func_ff == FUNC_ANGLE) begin
            dir_cw_in = ~angle_ff[ANGLE_W-1];
            steps_in  = steps_calc;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (steps_ff != '0) begin
                     steps_in = steps_ff - 1'b1;
                     phase_in = PH_HIGH;
                     count_in = high_eff;
                     low_in   = low_calc;
                  end
               end
               PH_HIGH: begin
                  count_in = count_dec;
                  if (count_dec == '0) begin
                     if (low_ff <= COUNT_W'(1)) begin
                        phase_in = PH_IDLE;
                        count_in = '0;
                     end else begin
                        phase_in = PH_LOW;
                        count_in = low_ff - 1'b1;
                     end
                  end
               end
               PH_LOW: begin
                  if (count_ff != '0) begin
                     count_in = count_dec;
                  end
                  if (count_ff <= COUNT_W'(1)) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff  <= '0;
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         low_ff    <= '0;
         dir_cw_ff <= 1'b1;
      end else begin
         steps_ff  <= steps_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         low_ff    <= low_in;
         dir_cw_ff <= dir_cw_in;
      end
   end

   // Input latch and result register
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         func_ff  <= req_func;
         angle_ff <= req_angle_deg;
      end
      if (cmd.commit) begin
         rsp_step_ff  <= (phase_in == PH_HIGH);
         rsp_dir_ff   <= dir_cw_in;
         rsp_mode_ff  <= mode_eff;
         rsp_steps_ff <= steps_in;
         rsp_busy_ff  <= (phase_in != PH_IDLE) || (steps_in != '0);
      end
   end

   assign rsp_step_level = rsp_step_ff;
   assign rsp_dir_motor1 = rsp_dir_ff;
   assign rsp_dir_motor2 = ~rsp_dir_ff;
   assign rsp_mode_pins  = rsp_mode_ff;
   assign rsp_steps_left = rsp_steps_ff;
   assign rsp_busy_res   = rsp_busy_ff;

endmodule

FILE: design/ssp_ctrl.sv
// Controller: sequences item acceptance, divisions and result hand-off.
module ssp_ctrl
   import ssp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_PREP     = 6'b000010,
      ST_WAIT_CMD = 6'b000100,
      ST_WAIT_RPM = 6'b001000,
      ST_WAIT_PPR = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The result register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.take_req  = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DIV_STEPS;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = ST_PREP;
            end
         end
         ST_PREP: begin
            if (stat.is_cmd) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_STEPS;
               state_in      = ST_WAIT_CMD;
            end else if (stat.pulse_start) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_PER_REV;
               state_in      = ST_WAIT_RPM;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_WAIT_CMD: begin
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_WAIT_RPM: begin
            cmd.div_sel = DIV_PER_PULSE;
            if (stat.div_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_WAIT_PPR;
            end
         end
         ST_WAIT_PPR: begin
            cmd.div_sel = DIV_PER_PULSE;
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.div_sel = DIV_PER_PULSE;
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/stepper_step_pulse_generator.sv
// Top level of the stepper step pulse generator: register port, controller and datapath.
// Each input beat is either an angle command or a one-microsecond tick, and each one
// yields exactly one result beat with the step line level, the direction pair, the
// microstep pins and the pending step count. Items are handled one at a time; a finished
// result waits in an output register while the next beat is already taken. An angle
// command runs one division on the shared divider, which resolves two quotient bits per
// cycle, and a tick that starts a new pulse runs two chained ones for the low time of
// the new pulse. Any other tick needs no division. Configuration is written through the
// APB-style port at byte addresses 0, 4, 8 and 12 and should only be changed while the
// block is idle.
module stepper_step_pulse_generator
   import ssp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ssp_req_if.sink               req_chan,
   ssp_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   ssp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_chan.func),
      .req_angle_deg  (req_chan.angle_deg),
      .rsp_step_level (rsp_chan.step_level),
      .rsp_dir_motor1 (rsp_chan.dir_motor1),
      .rsp_dir_motor2 (rsp_chan.dir_motor2),
      .rsp_mode_pins  (rsp_chan.mode_pins),
      .rsp_steps_left (rsp_chan.steps_left),
      .rsp_busy_res   (rsp_chan.busy_res)
   );

endmodule

FILE: design/ssp_checker.sv
// Port-level checks of the stepper step pulse generator and their binding.
module ssp_checker
   import ssp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               step_level,
   input logic               dir_motor1,
   input logic               dir_motor2,
   input logic [MODE_W-1:0]  mode_pins,
   input logic [STEPS_W-1:0] steps_left,
   input logic               busy_res
);

   // The two direction lines always point opposite ways.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (dir_motor2 == !dir_motor1))
      else $error("direction pair not complementary");

   // A high step line or pending steps always report busy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (step_level || (steps_left != '0))) |-> busy_res)
      else $error("busy flag missing while work remains");

   // One item at a time: a taken beat closes the input until its work is done.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input reopened right after a beat");

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(step_level) &&
         $stable(dir_motor1) && $stable(mode_pins) && $stable(steps_left) &&
         $stable(busy_res)))
      else $error("stalled result beat changed");

endmodule

bind stepper_step_pulse_generator ssp_checker u_ssp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .step_level (rsp_chan.step_level),
   .dir_motor1 (rsp_chan.dir_motor1),
   .dir_motor2 (rsp_chan.dir_motor2),
   .mode_pins  (rsp_chan.mode_pins),
   .steps_left (rsp_chan.steps_left),
   .busy_res   (rsp_chan.busy_res)
);
